// File: hw/rtl/obj_tri_pkg.sv
package obj_tri_pkg;

  // Fixed width of the corner fields on the result port.
  localparam int CORNER_BITS = 24;

  // Default width of the internal signed vertex index.
  localparam int INDEX_BITS_DEFAULT = 24;

  // ASCII codes the scanner reacts to.
  localparam logic [7:0] CHAR_F       = 8'h66;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;

  // Scanner phase, one-hot.
  typedef enum logic [5:0] {
    PH_LINE_START = 6'b000001,
    PH_SAW_F      = 6'b000010,
    PH_GAP        = 6'b000100,
    PH_NUMBER     = 6'b001000,
    PH_SKIP_ENTRY = 6'b010000,
    PH_SKIP_LINE  = 6'b100000
  } phase_t;

  // One triangle word.
  typedef struct packed {
    logic [CORNER_BITS-1:0] first;
    logic [CORNER_BITS-1:0] previous;
    logic [CORNER_BITS-1:0] current;
    logic                   starts_face;
    logic                   clipped;
  } tri_word_t;

endpackage

// File: hw/rtl/obj_face_line_triangulator_core.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------------------
// input    | in_valid / in_ready   | text_byte[7:0], end_of_text
// output   | out_valid / out_ready | corner_first/previous/current[23:0] (signed),
//          |                       | starts_face, index_clipped
//
// One byte is taken per cycle while in_ready is high; scan state updates on the accepting edge.
// A triangle word is registered into the output register, or into the skid slot if the output is stalled.
// Throughput is bound by the output register plus a one-word skid buffer:
// in_ready drops only while the skid slot holds a word.
// Reset (rst, synchronous) returns the scanner to line start with an empty fan.
module obj_face_line_triangulator_core #(
  parameter int INDEX_BITS = obj_tri_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [7:0]                                text_byte,
  input  logic                                      end_of_text,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [obj_tri_pkg::CORNER_BITS-1:0] corner_first,
  output logic signed [obj_tri_pkg::CORNER_BITS-1:0] corner_previous,
  output logic signed [obj_tri_pkg::CORNER_BITS-1:0] corner_current,
  output logic                                      starts_face,
  output logic                                      index_clipped
);

  // Accumulator math runs 4 bits wider so acc*10+9 never wraps before the clip test.
  localparam int ACC_W = INDEX_BITS + 4;
  localparam int EXT_W = (INDEX_BITS > obj_tri_pkg::CORNER_BITS) ?
                         INDEX_BITS : obj_tri_pkg::CORNER_BITS;
  localparam logic [ACC_W-1:0]      HALF_WIDE = ACC_W'(1) << (INDEX_BITS - 1);
  localparam logic [INDEX_BITS-1:0] HALF      = INDEX_BITS'(1) << (INDEX_BITS - 1);
  localparam logic [INDEX_BITS-1:0] IDX_MIN   = HALF;
  localparam logic [INDEX_BITS-1:0] IDX_MAX   = ~HALF;

  // Scan state
  obj_tri_pkg::phase_t    phase, phase_next;
  logic [INDEX_BITS-1:0]  acc, acc_next;
  logic                   neg, neg_next;
  logic                   sat, sat_next;
  logic [INDEX_BITS-1:0]  first_idx, first_idx_next;
  logic [INDEX_BITS-1:0]  prev_idx, prev_idx_next;
  logic                   first_clip, first_clip_next;
  logic                   prev_clip, prev_clip_next;
  logic [1:0]             entries, entries_next;

  // Output register and skid slot
  obj_tri_pkg::tri_word_t out_word, skid_word, res_word;
  logic                   skid_valid;
  logic                   res_valid;

  logic in_fire;
  logic out_slot_free;

  // Byte classification
  logic                   is_digit, is_space, is_nl, is_minus, is_f;
  logic [3:0]             digit;
  logic [ACC_W-1:0]       acc_sum;
  logic                   complete;
  logic [INDEX_BITS-1:0]  cur_idx;
  logic                   cur_clip;
  logic signed [EXT_W-1:0] ext_first, ext_prev, ext_cur;

  assign in_ready      = !skid_valid;
  assign in_fire       = in_valid && in_ready;
  assign out_slot_free = !out_valid || out_ready;

  assign is_digit = (text_byte >= obj_tri_pkg::CHAR_ZERO) &&
                    (text_byte <= obj_tri_pkg::CHAR_NINE);
  assign is_space = (text_byte == obj_tri_pkg::CHAR_SPACE);
  assign is_nl    = (text_byte == obj_tri_pkg::CHAR_NEWLINE);
  assign is_minus = (text_byte == obj_tri_pkg::CHAR_MINUS);
  assign is_f     = (text_byte == obj_tri_pkg::CHAR_F);
  assign digit    = 4'(text_byte - obj_tri_pkg::CHAR_ZERO);

  // acc*10 + digit as two shifts and two adds
  assign acc_sum = (ACC_W'(acc) << 3) + (ACC_W'(acc) << 1) + ACC_W'(digit);

  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    neg_next        = neg;
    sat_next        = sat;
    first_idx_next  = first_idx;
    prev_idx_next   = prev_idx;
    first_clip_next = first_clip;
    prev_clip_next  = prev_clip;
    entries_next    = entries;
    complete        = 1'b0;
    cur_idx         = '0;
    cur_clip        = 1'b0;
    res_valid       = 1'b0;
    ext_first       = '0;
    ext_prev        = '0;
    ext_cur         = '0;

    unique case (phase)
      obj_tri_pkg::PH_LINE_START: begin
        if (is_f) phase_next = obj_tri_pkg::PH_SAW_F;
        else if (is_nl) phase_next = obj_tri_pkg::PH_LINE_START;
        else phase_next = obj_tri_pkg::PH_SKIP_LINE;
      end
      obj_tri_pkg::PH_SAW_F: begin
        phase_next = is_space ? obj_tri_pkg::PH_GAP : obj_tri_pkg::PH_SKIP_LINE;
      end
      obj_tri_pkg::PH_GAP: begin
        if (is_minus || is_digit) begin
          neg_next   = is_minus;
          acc_next   = is_minus ? '0 : INDEX_BITS'(digit);
          sat_next   = 1'b0;
          phase_next = obj_tri_pkg::PH_NUMBER;
          complete   = end_of_text;
        end
      end
      obj_tri_pkg::PH_NUMBER: begin
        if (is_digit) begin
          if (acc_sum > HALF_WIDE) begin
            acc_next = HALF;
            sat_next = 1'b1;
          end else begin
            acc_next = acc_sum[INDEX_BITS-1:0];
          end
          complete = end_of_text;
        end else begin
          complete   = 1'b1;
          phase_next = is_space ? obj_tri_pkg::PH_GAP : obj_tri_pkg::PH_SKIP_ENTRY;
        end
      end
      obj_tri_pkg::PH_SKIP_ENTRY: begin
        if (is_space) phase_next = obj_tri_pkg::PH_GAP;
      end
      obj_tri_pkg::PH_SKIP_LINE: begin
        phase_next = obj_tri_pkg::PH_SKIP_LINE;
      end
      default: begin
        phase_next = obj_tri_pkg::PH_SKIP_LINE;
      end
    endcase

    // Number to clipped zero-based index; -acc-1 is ~acc in two's complement
    if (neg_next) begin
      if (sat_next || acc_next > IDX_MAX) begin
        cur_idx  = IDX_MIN;
        cur_clip = 1'b1;
      end else begin
        cur_idx = ~acc_next;
      end
    end else if (sat_next) begin
      cur_idx  = IDX_MAX;
      cur_clip = 1'b1;
    end else begin
      cur_idx = acc_next - INDEX_BITS'(1);
    end

    // Fan bookkeeping
    if (complete) begin
      if (entries == 2'd0) begin
        first_idx_next  = cur_idx;
        first_clip_next = cur_clip;
        entries_next    = 2'd1;
      end else if (entries == 2'd1) begin
        entries_next = 2'd2;
      end else begin
        res_valid    = 1'b1;
        entries_next = 2'd3;
      end
      prev_idx_next  = cur_idx;
      prev_clip_next = cur_clip;
    end

    // Sign-extend (or truncate) to the port width
    ext_first = EXT_W'($signed(first_idx));
    ext_prev  = EXT_W'($signed(prev_idx));
    ext_cur   = EXT_W'($signed(cur_idx));

    if (is_nl || end_of_text) begin
      phase_next   = obj_tri_pkg::PH_LINE_START;
      entries_next = 2'd0;
    end
  end

  assign res_word.first       = ext_first[obj_tri_pkg::CORNER_BITS-1:0];
  assign res_word.previous    = ext_prev[obj_tri_pkg::CORNER_BITS-1:0];
  assign res_word.current     = ext_cur[obj_tri_pkg::CORNER_BITS-1:0];
  assign res_word.starts_face = (entries == 2'd2);
  assign res_word.clipped     = first_clip || prev_clip || cur_clip;

  // Scan state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= obj_tri_pkg::PH_LINE_START;
      acc        <= '0;
      neg        <= 1'b0;
      sat        <= 1'b0;
      first_idx  <= '0;
      prev_idx   <= '0;
      first_clip <= 1'b0;
      prev_clip  <= 1'b0;
      entries    <= 2'd0;
    end else if (in_fire) begin
      phase      <= phase_next;
      acc        <= acc_next;
      neg        <= neg_next;
      sat        <= sat_next;
      first_idx  <= first_idx_next;
      prev_idx   <= prev_idx_next;
      first_clip <= first_clip_next;
      prev_clip  <= prev_clip_next;
      entries    <= entries_next;
    end
  end

  // Output register with skid slot: a word that finds the output stalled parks in skid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_slot_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire && res_valid;
      end
    end else if (in_fire && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_slot_free) begin
      if (skid_valid) out_word <= skid_word;
      else if (in_fire && res_valid) out_word <= res_word;
    end else if (in_fire && res_valid) begin
      skid_word <= res_word;
    end
  end

  assign corner_first    = out_word.first;
  assign corner_previous = out_word.previous;
  assign corner_current  = out_word.current;
  assign starts_face     = out_word.starts_face;
  assign index_clipped   = out_word.clipped;

  // Skid only ever holds a word behind a valid output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word without output word");

  // Skid fills only when the output was stalled
  a_skid_fill_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid filled while output was free");

  // A newline or final byte always clears the fan
  a_line_end_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && (is_nl || end_of_text) |=> entries == 2'd0 &&
      phase == obj_tri_pkg::PH_LINE_START)
    else $error("line end did not clear fan state");

  // Triangles come only out of entry parsing on a full fan
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (entries != 2'd0 && entries != 2'd1) &&
      (phase == obj_tri_pkg::PH_NUMBER || phase == obj_tri_pkg::PH_GAP))
    else $error("triangle from unexpected phase or fan count");

  a_phase_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(phase))
    else $error("scan phase not one-hot");

endmodule
